// ===== design/lpfp_pkg.sv =====
// Shared types and constants for the length-prefixed field parser.
package lpfp_pkg;

  localparam int unsigned HdrDigitsW = 3;
  localparam int unsigned LenW       = 14;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned ErrW       = 2;
  localparam int unsigned OutDataW   = 24;

  localparam logic [HdrDigitsW-1:0] HdrDigitsReset = 3'd3;
  localparam logic [HdrDigitsW-1:0] HdrCountMax    = 3'd7;
  localparam logic [LenW-1:0]       MaxSizeReset   = 14'd999;
  localparam logic [LenW-1:0]       LenSat         = 14'd16383;

  localparam logic CfgHdrDigits = 1'b0;
  localparam logic CfgMaxSize   = 1'b1;

  localparam logic OpByte = 1'b0;
  localparam logic OpEnd  = 1'b1;

  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChPlus  = 8'h2B;
  localparam logic [ByteW-1:0] ChMinus = 8'h2D;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PAYLOAD,
    PH_DRAIN
  } phase_t;

  typedef enum logic [1:0] {
    SCAN_SPACE,
    SCAN_SIGN,
    SCAN_DIGITS
  } scan_t;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE    = 2'd0,
    ERR_SHORT   = 2'd1,
    ERR_BAD_HDR = 2'd2,
    ERR_BAD_LEN = 2'd3
  } err_t;

endpackage

// ===== design/length_prefixed_field_parser_core.sv =====
// Length-prefixed field parser: splits a byte stream into length-headed fields.
// Each accepted request's result is captured in the output register.
// Throughput: one request per cycle while the output register is not stalled.
// The input is accepted while the output register is empty or being drained.
// Synchronous active-low reset idles the parser and restores its control registers.
module length_prefixed_field_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [13:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tuser,   // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_byte, [9:8] error_code, [23:10] field_length
  output logic        out_tuser,  // [0] payload_valid
  output logic        out_tlast   // field_done
);

  logic [lpfp_pkg::HdrDigitsW-1:0] hdr_digits_r;
  logic [lpfp_pkg::LenW-1:0]       max_size_r;

  lpfp_pkg::phase_t                phase_r, phase_nxt;
  lpfp_pkg::scan_t                 scan_r, scan_nxt;
  logic [lpfp_pkg::HdrDigitsW-1:0] count_r, count_nxt;
  logic                            bad_r, bad_nxt;
  logic                            neg_r, neg_nxt;
  logic [lpfp_pkg::LenW-1:0]       accum_r, accum_nxt;
  logic [lpfp_pkg::LenW-1:0]       left_r, left_nxt;

  logic                            res_valid;
  logic [lpfp_pkg::ByteW-1:0]      res_byte;
  logic                            res_done;
  lpfp_pkg::err_t                  res_err;
  logic [lpfp_pkg::LenW-1:0]       res_len;

  logic                            out_valid_r, out_valid_nxt;
  logic [lpfp_pkg::OutDataW-1:0]   out_data_r;
  logic                            out_user_r;
  logic                            out_last_r;

  logic                            in_acc;
  logic                            is_digit;
  logic                            is_space;
  logic [17:0]                     acc_mul;
  logic [lpfp_pkg::LenW-1:0]       acc_digit;
  logic                            finished;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  assign is_digit = (in_tdata >= lpfp_pkg::ChZero) && (in_tdata <= lpfp_pkg::ChNine);
  assign is_space = (in_tdata == lpfp_pkg::ChSpace) ||
                    ((in_tdata >= lpfp_pkg::ChTab) && (in_tdata <= lpfp_pkg::ChCr));

  // Decimal accumulate with saturation at the largest 14-bit value.
  assign acc_mul   = ({4'd0, accum_r} << 3) + ({4'd0, accum_r} << 1) +
                     {10'd0, in_tdata - lpfp_pkg::ChZero};
  assign acc_digit = (acc_mul > {4'd0, lpfp_pkg::LenSat}) ? lpfp_pkg::LenSat
                                                          : acc_mul[lpfp_pkg::LenW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_digits_r <= lpfp_pkg::HdrDigitsReset;
      max_size_r   <= lpfp_pkg::MaxSizeReset;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lpfp_pkg::CfgHdrDigits: hdr_digits_r <= cfg_wdata[lpfp_pkg::HdrDigitsW-1:0];
        lpfp_pkg::CfgMaxSize:   max_size_r   <= cfg_wdata;
        default:                hdr_digits_r <= hdr_digits_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lpfp_pkg::PH_IDLE;
      scan_r  <= lpfp_pkg::SCAN_SPACE;
      count_r <= '0;
      bad_r   <= 1'b0;
      neg_r   <= 1'b0;
      accum_r <= '0;
      left_r  <= '0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      scan_r  <= scan_nxt;
      count_r <= count_nxt;
      bad_r   <= bad_nxt;
      neg_r   <= neg_nxt;
      accum_r <= accum_nxt;
      left_r  <= left_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    scan_nxt  = scan_r;
    count_nxt = count_r;
    bad_nxt   = bad_r;
    neg_nxt   = neg_r;
    accum_nxt = accum_r;
    left_nxt  = left_r;
    res_valid = 1'b0;
    res_byte  = '0;
    res_done  = 1'b0;
    res_err   = lpfp_pkg::ERR_NONE;
    res_len   = '0;
    finished  = 1'b0;

    if (in_tuser == lpfp_pkg::OpEnd) begin
      if (phase_r == lpfp_pkg::PH_HEADER || phase_r == lpfp_pkg::PH_PAYLOAD) begin
        res_err = lpfp_pkg::ERR_SHORT;
      end
      phase_nxt = lpfp_pkg::PH_IDLE;
      scan_nxt  = lpfp_pkg::SCAN_SPACE;
      count_nxt = '0;
      bad_nxt   = 1'b0;
      neg_nxt   = 1'b0;
      accum_nxt = '0;
      left_nxt  = '0;
    end else if (phase_r != lpfp_pkg::PH_DRAIN) begin
      if (phase_r == lpfp_pkg::PH_IDLE) begin
        scan_nxt  = lpfp_pkg::SCAN_SPACE;
        count_nxt = '0;
        bad_nxt   = 1'b0;
        neg_nxt   = 1'b0;
        accum_nxt = '0;
        left_nxt  = '0;
        if (hdr_digits_r == '0) begin
          if (max_size_r == '0) begin
            res_done = 1'b1;
            finished = 1'b1;
          end else begin
            accum_nxt = max_size_r;
            left_nxt  = max_size_r;
            phase_nxt = lpfp_pkg::PH_PAYLOAD;
          end
        end else begin
          phase_nxt = lpfp_pkg::PH_HEADER;
        end
      end

      if (!finished && phase_nxt == lpfp_pkg::PH_HEADER) begin
        if (!bad_nxt) begin
          if (scan_nxt == lpfp_pkg::SCAN_SPACE && is_space) begin
            scan_nxt = lpfp_pkg::SCAN_SPACE;
          end else if (scan_nxt == lpfp_pkg::SCAN_SPACE &&
                       (in_tdata == lpfp_pkg::ChPlus || in_tdata == lpfp_pkg::ChMinus)) begin
            scan_nxt = lpfp_pkg::SCAN_SIGN;
            neg_nxt  = (in_tdata == lpfp_pkg::ChMinus);
          end else if (is_digit) begin
            scan_nxt  = lpfp_pkg::SCAN_DIGITS;
            accum_nxt = acc_digit;
          end else begin
            bad_nxt = 1'b1;
          end
        end
        if (count_nxt < lpfp_pkg::HdrCountMax) begin
          count_nxt = count_nxt + 1'b1;
        end
        if (count_nxt >= hdr_digits_r) begin
          priority if (bad_nxt || scan_nxt != lpfp_pkg::SCAN_DIGITS) begin
            res_err = lpfp_pkg::ERR_BAD_HDR;
            phase_nxt = lpfp_pkg::PH_DRAIN;
          end else if ((neg_nxt && accum_nxt != '0) || accum_nxt > max_size_r) begin
            res_err = lpfp_pkg::ERR_BAD_LEN;
            phase_nxt = lpfp_pkg::PH_DRAIN;
          end else if (accum_nxt == '0) begin
            res_done  = 1'b1;
            phase_nxt = lpfp_pkg::PH_IDLE;
          end else begin
            res_len   = accum_nxt;
            left_nxt  = accum_nxt;
            phase_nxt = lpfp_pkg::PH_PAYLOAD;
          end
          if (phase_nxt != lpfp_pkg::PH_PAYLOAD) begin
            scan_nxt  = lpfp_pkg::SCAN_SPACE;
            count_nxt = '0;
            bad_nxt   = 1'b0;
            neg_nxt   = 1'b0;
            accum_nxt = '0;
            left_nxt  = '0;
          end
        end
      end else if (!finished) begin
        res_valid = 1'b1;
        res_byte  = in_tdata;
        res_len   = accum_nxt;
        if (left_nxt != '0) begin
          left_nxt = left_nxt - 1'b1;
        end
        if (left_nxt == '0) begin
          res_done  = 1'b1;
          phase_nxt = lpfp_pkg::PH_IDLE;
          scan_nxt  = lpfp_pkg::SCAN_SPACE;
          count_nxt = '0;
          bad_nxt   = 1'b0;
          neg_nxt   = 1'b0;
          accum_nxt = '0;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= {res_len, res_err, res_byte};
      out_user_r <= res_valid;
      out_last_r <= res_done;
    end
  end

`ifndef SYNTH
  a_done_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_data_r[9:8] == lpfp_pkg::ERR_NONE))
    else $error("field end reported together with an error");

  a_payload_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_user_r) |-> (out_data_r[9:8] == lpfp_pkg::ERR_NONE))
    else $error("payload byte reported together with an error");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled while the output register is empty");

  a_header_error_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (res_err == lpfp_pkg::ERR_BAD_HDR || res_err == lpfp_pkg::ERR_BAD_LEN))
    |=> (phase_r == lpfp_pkg::PH_DRAIN))
    else $error("header error did not stop parsing");

  a_count_only_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != lpfp_pkg::PH_PAYLOAD) |-> (left_r == '0))
    else $error("payload count left over outside a payload");
`endif

endmodule
